[rtl/nwu_pkg.sv]
// shared types, register codes and saturation helper for the weight update engine
package nwu_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_MODE,
		CFG_STEP_SCALE,
		CFG_QP_MU,
		CFG_QP_DECAY,
		CFG_STEP_MIN,
		CFG_STEP_MAX,
		CFG_GROW,
		CFG_SHRINK
	} cfg_idx_t;

	// update modes
	localparam logic [1:0] MODE_BATCH = 2'd0;
	localparam logic [1:0] MODE_QPROP = 2'd1;
	localparam logic [1:0] MODE_RPROP = 2'd2;

	// item kinds
	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_RESET  = 1'b1;

	// register reset values
	localparam logic [1:0]         RST_MODE       = MODE_RPROP;
	localparam logic [30:0]        RST_STEP_SCALE = 31'd45875;
	localparam logic [30:0]        RST_QP_MU      = 31'd114688;
	localparam logic signed [31:0] RST_QP_DECAY   = -32'sd7;
	localparam logic [30:0]        RST_STEP_MIN   = 31'd0;
	localparam logic [30:0]        RST_STEP_MAX   = 31'd3276800;
	localparam logic [30:0]        RST_GROW       = 31'd78643;
	localparam logic [30:0]        RST_SHRINK     = 31'd32768;

	localparam logic signed [65:0] S32_MAX66 = 66'sh0_7FFF_FFFF;
	localparam logic signed [65:0] S32_MIN66 = -66'sh0_8000_0000;

	// input item as it moves down the front stages
	typedef struct packed {
		logic               kind;
		logic [9:0]         idx;
		logic               ok;
		logic signed [31:0] w;
		logic signed [31:0] slope;
		logic signed [31:0] init;
	} itm_t;

	// result item as it moves down the back stages
	typedef struct packed {
		logic [9:0]         idx;
		logic signed [31:0] w;
		logic signed [31:0] w_o;
		logic signed [31:0] step_o;
		logic signed [31:0] slope_o;
		logic               wr;
		logic               qp;
	} res_t;

	// clamp a wide signed value to 32-bit signed
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX66) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < S32_MIN66) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

endpackage

[rtl/nwu_if.sv]
// valid/ready channels for update items and result items

interface nwu_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [9:0]         weight_index;
	logic signed [31:0] weight_in;
	logic signed [31:0] slope_in;
	logic signed [31:0] initial_step;

	modport source(output valid, kind, weight_index, weight_in, slope_in, initial_step,
		input ready);
	modport sink(input valid, kind, weight_index, weight_in, slope_in, initial_step,
		output ready);
endinterface

interface nwu_out_if;
	logic               valid;
	logic               ready;
	logic [9:0]         out_index;
	logic signed [31:0] weight_out;
	logic signed [31:0] step_out;

	modport source(output valid, out_index, weight_out, step_out, input ready);
	modport sink(input valid, out_index, weight_out, step_out, output ready);
endinterface

[rtl/nwu_ram.sv]
// generic single write port ram with registered read
module nwu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[rtl/nn_weight_update_engine_core.sv]
// top level of the per-weight batch / quickprop / rprop update engine
//
// Update items enter on in_ch and one result per item leaves on out_ch, both
// valid/ready; a transaction happens on an edge with valid and ready high.
// Registers are written through cfg_we / cfg_index / cfg_data; the user
// must do so only while idle, which the block itself does not enforce.
// An item passes five arithmetic stages, a restoring divider of
// 64 - FRAC_BITS one-bit stages for the quickprop quotient, and the output
// register. One item is taken per cycle while in_ch.ready is high. An item
// whose index matches one still in flight waits until that one has written
// its history back, since the history read comes from the single read port
// of the history ram. After reset and after each qprop_mu write a shared
// serial divider forms the quickprop shrink factor; no item is taken
// meanwhile. Reset clears all valid bits and loads register defaults; the
// history ram is not cleared and an index must see a reset item first.
// When out_ch is stalled the whole pipeline holds and in_ch.ready drops.
module nn_weight_update_engine_core
	import nwu_pkg::*;
#(
	parameter int WEIGHT_COUNT = 1024,
	parameter int FRAC_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	nwu_in_if.sink      in_ch,
	nwu_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int AW = WEIGHT_COUNT > 1 ? $clog2(WEIGHT_COUNT) : 1;
	localparam int QB = 64 - FRAC_BITS;
	localparam int CW = $clog2(FRAC_BITS + 1);
	localparam logic [31:0] FX_ONE = 32'(64'(1) << FRAC_BITS);
	localparam longint EPS_L = ((longint'(1) << FRAC_BITS) + 500) / 1000;
	localparam logic signed [31:0] QP_EPS  = 32'(EPS_L);
	localparam logic signed [31:0] QP_NEPS = -32'(EPS_L);

	// configuration registers
	logic [1:0]         mode_q;
	logic [30:0]        scale_q, mu_q, smin_q, smax_q, grow_q, shr_q;
	logic signed [31:0] decay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= RST_MODE;
			scale_q <= RST_STEP_SCALE;
			mu_q    <= RST_QP_MU;
			decay_q <= RST_QP_DECAY;
			smin_q  <= RST_STEP_MIN;
			smax_q  <= RST_STEP_MAX;
			grow_q  <= RST_GROW;
			shr_q   <= RST_SHRINK;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MODE:       mode_q  <= cfg_data[1:0];
				CFG_STEP_SCALE: scale_q <= cfg_data[30:0];
				CFG_QP_MU:      mu_q    <= cfg_data[30:0];
				CFG_QP_DECAY:   decay_q <= cfg_data;
				CFG_STEP_MIN:   smin_q  <= cfg_data[30:0];
				CFG_STEP_MAX:   smax_q  <= cfg_data[30:0];
				CFG_GROW:       grow_q  <= cfg_data[30:0];
				CFG_SHRINK:     shr_q   <= cfg_data[30:0];
				default:        mode_q  <= mode_q;
			endcase
		end
	end

	// serial divider for the quickprop shrink factor mu / (mu + 1)
	logic                 sbusy_q;
	logic [CW-1:0]        scnt_q;
	logic [31:0]          srem_q;
	logic [FRAC_BITS-1:0] squo_q;
	logic [31:0]          sdiv;
	logic [32:0]          srs;
	logic                 sge;

	assign sdiv = 32'(mu_q) + FX_ONE;
	assign srs  = {srem_q, 1'b0};
	assign sge  = srs >= 33'(sdiv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbusy_q <= 1'b1;
			scnt_q  <= '0;
			srem_q  <= 32'(RST_QP_MU);
			squo_q  <= '0;
		end else if (cfg_we && cfg_idx_t'(cfg_index) == CFG_QP_MU) begin
			sbusy_q <= 1'b1;
			scnt_q  <= '0;
			srem_q  <= {1'b0, cfg_data[30:0]};
			squo_q  <= '0;
		end else if (sbusy_q) begin
			srem_q  <= sge ? 32'(srs - 33'(sdiv)) : 32'(srs);
			squo_q  <= FRAC_BITS'({squo_q, sge});
			scnt_q  <= scnt_q + 1'b1;
			if (scnt_q == CW'(FRAC_BITS - 1)) begin
				sbusy_q <= 1'b0;
			end
		end
	end

	// pipeline control
	logic          adv, haz, accept;
	logic          out_v_q;
	logic          v_s1, v_s2, v_s3, v_s4, v_s5;
	itm_t          it_s1, it_s2, it_s3;
	res_t          res_s4, res_s5;
	logic          dv_v   [QB];
	res_t          dv_res [QB];
	logic [QB-1:0] dv_hit;

	assign adv    = !out_v_q || out_ch.ready;
	assign haz    = (v_s1 && it_s1.idx == in_ch.weight_index)
		|| (v_s2 && it_s2.idx == in_ch.weight_index)
		|| (v_s3 && it_s3.idx == in_ch.weight_index)
		|| (v_s4 && res_s4.idx == in_ch.weight_index)
		|| (v_s5 && res_s5.idx == in_ch.weight_index)
		|| (|dv_hit);
	assign in_ch.ready = adv && !sbusy_q && !haz;
	assign accept = in_ch.valid && in_ch.ready;

	// history ram: slope in the upper half, step in the lower half
	logic        h_we;
	logic [63:0] h_wdata, h_rdata;
	res_t        fin;

	nwu_ram #(.WIDTH(64), .DEPTH(WEIGHT_COUNT)) u_hist (
		.clk   (clk),
		.we    (h_we),
		.waddr (AW'(fin.idx)),
		.wdata (h_wdata),
		.re    (accept),
		.raddr (AW'(in_ch.weight_index)),
		.rdata (h_rdata)
	);

	// stage 1: capture transaction, history arrives from ram
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1.kind  <= in_ch.kind;
			it_s1.idx   <= in_ch.weight_index;
			it_s1.ok    <= 32'(in_ch.weight_index) < 32'(WEIGHT_COUNT);
			it_s1.w     <= in_ch.weight_in;
			it_s1.slope <= in_ch.slope_in;
			it_s1.init  <= in_ch.initial_step;
		end
	end

	// stage 1 logic: first products and rprop base step
	logic signed [31:0] ps1, pt1, base1, smin_s;
	logic signed [63:0] m_dw1, m_bs1, m_lim1, m_mu1;

	assign ps1    = it_s1.ok ? $signed(h_rdata[63:32]) : 32'sd0;
	assign pt1    = it_s1.ok ? $signed(h_rdata[31:0]) : 32'sd0;
	assign smin_s = $signed({1'b0, smin_q});
	assign base1  = pt1 > smin_s ? pt1 : smin_s;
	assign m_dw1  = 64'(decay_q) * 64'(it_s1.w);
	assign m_bs1  = 64'(it_s1.slope) * 64'($signed({1'b0, scale_q}));
	assign m_lim1 = 64'($signed({1'b0, squo_q})) * 64'(ps1);
	assign m_mu1  = 64'($signed({1'b0, mu_q})) * 64'(pt1);

	logic signed [31:0] ps_s2, pt_s2, base_s2;
	logic signed [63:0] m_dw_s2, m_bs_s2, m_lim_s2, m_mu_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s2    <= it_s1;
			ps_s2    <= ps1;
			pt_s2    <= pt1;
			base_s2  <= base1;
			m_dw_s2  <= m_dw1;
			m_bs_s2  <= m_bs1;
			m_lim_s2 <= m_lim1;
			m_mu_s2  <= m_mu1;
		end
	end

	// stage 2 logic: decayed slope, batch weight, rprop products
	logic signed [31:0] cur2, bw2;
	logic signed [63:0] m_gr2, m_sh2;

	assign cur2  = sat32(66'(it_s2.slope) + 66'(m_dw_s2 >>> FRAC_BITS));
	assign bw2   = sat32(66'(it_s2.w) + 66'(m_bs_s2 >>> FRAC_BITS));
	assign m_gr2 = 64'(base_s2) * 64'($signed({1'b0, grow_q}));
	assign m_sh2 = 64'(base_s2) * 64'($signed({1'b0, shr_q}));

	logic signed [31:0] ps_s3, pt_s3, cur_s3, bw_s3;
	logic signed [63:0] lim_s3, mus_s3, m_gr_s3, m_sh_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s3   <= it_s2;
			ps_s3   <= ps_s2;
			pt_s3   <= pt_s2;
			cur_s3  <= cur2;
			bw_s3   <= bw2;
			lim_s3  <= m_lim_s2 >>> FRAC_BITS;
			mus_s3  <= m_mu_s2 >>> FRAC_BITS;
			m_gr_s3 <= m_gr2;
			m_sh_s3 <= m_sh2;
		end
	end

	// stage 3 logic: rprop result, quickprop decisions and products
	logic signed [63:0] gr3, sh3, st_r3, smax64, smin64;
	logic signed [31:0] rstep3, rcur3, rw3;
	logic               flip3, pos3, neg3, zero3, addmu3, adddiv3;
	logic signed [63:0] m_num3, m_sc3;
	logic signed [32:0] den3;
	res_t               res3;

	assign smax64  = 64'($signed({1'b0, smax_q}));
	assign smin64  = 64'($signed({1'b0, smin_q}));
	assign gr3     = (m_gr_s3 >>> FRAC_BITS) > smax64 ? smax64 : (m_gr_s3 >>> FRAC_BITS);
	assign sh3     = (m_sh_s3 >>> FRAC_BITS) < smin64 ? smin64 : (m_sh_s3 >>> FRAC_BITS);
	assign flip3   = (ps_s3 > 0 && it_s3.slope < 0) || (ps_s3 < 0 && it_s3.slope > 0);
	assign st_r3   = flip3 ? sh3 : gr3;
	assign rstep3  = sat32(66'(st_r3));
	assign rcur3   = flip3 ? 32'sd0 : it_s3.slope;
	assign rw3     = sat32(rcur3 < 0 ? 66'(it_s3.w) - 66'(rstep3)
		: 66'(it_s3.w) + 66'(rstep3));
	assign m_num3  = 64'(pt_s3) * 64'(cur_s3);
	assign m_sc3   = 64'($signed({1'b0, scale_q})) * 64'(cur_s3);
	assign den3    = 33'(ps_s3) - 33'(cur_s3);
	assign pos3    = pt_s3 > QP_EPS;
	assign neg3    = pt_s3 < QP_NEPS;
	assign zero3   = (pos3 && cur_s3 <= 0) || (neg3 && cur_s3 >= 0);
	assign addmu3  = (pos3 && 64'(cur_s3) > lim_s3) || (neg3 && 64'(cur_s3) < lim_s3);
	assign adddiv3 = (pos3 || neg3) && !addmu3;

	// per-mode result before the quickprop quotient is known
	always_comb begin
		res3.idx     = it_s3.idx;
		res3.w       = it_s3.w;
		res3.w_o     = it_s3.w;
		res3.step_o  = pt_s3;
		res3.slope_o = ps_s3;
		res3.wr      = 1'b0;
		res3.qp      = 1'b0;
		if (it_s3.kind == KIND_RESET) begin
			res3.step_o  = it_s3.init;
			res3.slope_o = 32'sd0;
			res3.wr      = it_s3.ok;
		end else begin
			case (mode_q)
				MODE_BATCH: res3.w_o = bw_s3;
				MODE_QPROP: begin
					res3.slope_o = cur_s3;
					res3.wr      = it_s3.ok;
					res3.qp      = 1'b1;
				end
				MODE_RPROP: begin
					res3.w_o     = rw3;
					res3.step_o  = rstep3;
					res3.slope_o = rcur3;
					res3.wr      = it_s3.ok;
				end
				default: res3.w_o = it_s3.w;
			endcase
		end
	end

	logic signed [63:0] m_num_s4, m_sc_s4, mus_s4;
	logic signed [32:0] den_s4;
	logic               zero_s4, addmu_s4, adddiv_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s4    <= res3;
			m_num_s4  <= m_num3;
			m_sc_s4   <= m_sc3;
			mus_s4    <= mus_s3;
			den_s4    <= den3;
			zero_s4   <= zero3;
			addmu_s4  <= addmu3;
			adddiv_s4 <= adddiv3;
		end
	end

	// stage 4 logic: step before quotient, operand magnitudes
	logic signed [65:0] stpre4;
	logic [62:0]        nmag4;
	logic [32:0]        dmag4;

	assign stpre4 = (zero_s4 ? 66'sd0 : 66'(m_sc_s4 >>> FRAC_BITS))
		+ (addmu_s4 ? 66'(mus_s4) : 66'sd0);
	assign nmag4  = m_num_s4[63] ? 63'(-m_num_s4) : 63'(m_num_s4);
	assign dmag4  = den_s4[32] ? 33'(-den_s4) : 33'(den_s4);

	logic signed [65:0] stpre_s5;
	logic [62:0]        nmag_s5;
	logic [32:0]        dmag_s5;
	logic               adddiv_s5, qneg_s5, nzero_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s5    <= res_s4;
			stpre_s5  <= stpre4;
			nmag_s5   <= nmag4;
			dmag_s5   <= dmag4;
			adddiv_s5 <= adddiv_s4;
			qneg_s5   <= m_num_s4[63] ^ den_s4[32];
			nzero_s5  <= m_num_s4 == 64'sd0;
		end
	end

	// stage 5 logic: quotient overflow check and divider start
	logic          ovf5;
	logic [32:0]   r0;
	logic [QB-1:0] n0;

	assign ovf5 = (nmag_s5 >> QB) >= 63'(dmag_s5);
	assign r0   = 33'(nmag_s5 >> QB);
	assign n0   = nmag_s5[QB-1:0];

	// restoring divider, one quotient bit per stage
	logic signed [65:0] dv_stpre [QB];
	logic               dv_add   [QB];
	logic               dv_qneg  [QB];
	logic               dv_nzero [QB];
	logic               dv_ovf   [QB];
	logic [32:0]        dv_d     [QB];
	logic [32:0]        dv_r     [QB];
	logic [QB-1:0]      dv_n     [QB];
	logic [QB-1:0]      dv_q     [QB];

	for (genvar k = 0; k < QB; k++) begin : g_div
		logic               pv, padd, pqneg, pnzero, povf, ge;
		res_t               pres;
		logic signed [65:0] pstpre;
		logic [32:0]        pd, pr;
		logic [QB-1:0]      pn, pq;
		logic [33:0]        rs;

		if (k == 0) begin : g_src
			assign pv     = v_s5;
			assign pres   = res_s5;
			assign pstpre = stpre_s5;
			assign padd   = adddiv_s5;
			assign pqneg  = qneg_s5;
			assign pnzero = nzero_s5;
			assign povf   = ovf5;
			assign pd     = dmag_s5;
			assign pr     = r0;
			assign pn     = n0;
			assign pq     = '0;
		end else begin : g_src
			assign pv     = dv_v[k-1];
			assign pres   = dv_res[k-1];
			assign pstpre = dv_stpre[k-1];
			assign padd   = dv_add[k-1];
			assign pqneg  = dv_qneg[k-1];
			assign pnzero = dv_nzero[k-1];
			assign povf   = dv_ovf[k-1];
			assign pd     = dv_d[k-1];
			assign pr     = dv_r[k-1];
			assign pn     = dv_n[k-1];
			assign pq     = dv_q[k-1];
		end

		assign rs = {pr, pn[QB-1]};
		assign ge = rs >= {1'b0, pd};
		assign dv_hit[k] = dv_v[k] && dv_res[k].idx == in_ch.weight_index;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k] <= 1'b0;
			end else if (adv) begin
				dv_v[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_res[k]   <= pres;
				dv_stpre[k] <= pstpre;
				dv_add[k]   <= padd;
				dv_qneg[k]  <= pqneg;
				dv_nzero[k] <= pnzero;
				dv_ovf[k]   <= povf;
				dv_d[k]     <= pd;
				dv_r[k]     <= ge ? 33'(rs - {1'b0, pd}) : 33'(rs);
				dv_n[k]     <= pn << 1;
				dv_q[k]     <= QB'({pq, ge});
			end
		end
	end

	// final: signed quotient, quickprop step and weight, history write
	// a zero divisor gives the 32-bit limit with the numerator's sign
	logic signed [65:0] qmag, qs;
	logic signed [31:0] stq;

	assign qmag = dv_ovf[QB-1] ? (66'sd1 <<< QB) : 66'(dv_q[QB-1]);
	assign qs   = dv_nzero[QB-1] ? 66'sd0
		: (dv_d[QB-1] == 33'd0) ? (dv_qneg[QB-1] ? S32_MIN66 : S32_MAX66)
		: (dv_qneg[QB-1] ? -qmag : qmag);
	assign stq  = sat32(dv_stpre[QB-1] + (dv_add[QB-1] ? qs : 66'sd0));

	always_comb begin
		fin = dv_res[QB-1];
		if (fin.qp) begin
			fin.step_o = stq;
			fin.w_o    = sat32(66'(fin.w) + 66'(stq));
		end
	end

	assign h_we    = adv && dv_v[QB-1] && fin.wr;
	assign h_wdata = {fin.slope_o, fin.step_o};

	// output register
	logic [9:0]         oidx_q;
	logic signed [31:0] ow_q, ostep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= dv_v[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oidx_q  <= fin.idx;
			ow_q    <= fin.w_o;
			ostep_q <= fin.step_o;
		end
	end

	assign out_ch.valid      = out_v_q;
	assign out_ch.out_index  = oidx_q;
	assign out_ch.weight_out = ow_q;
	assign out_ch.step_out   = ostep_q;
endmodule
